@@ src/one_shot_timer_slot_pool_core_macros.svh @@
// ----------------------------------------------------------------------------
// One-shot timer slot pool: assertion macros
// Shorthand for clocked, reset-qualified concurrent checks.
// ----------------------------------------------------------------------------
`ifndef ONE_SHOT_TIMER_SLOT_POOL_CORE_MACROS_SVH
`define ONE_SHOT_TIMER_SLOT_POOL_CORE_MACROS_SVH

// Same-cycle implication
`define OTSP_ASSERT_IMPL(name, ante, cons) \
name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("otsp: same-cycle check failed");

// Next-cycle implication
`define OTSP_ASSERT_NEXT(name, ante, cons) \
name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("otsp: next-cycle check failed");

`endif

@@ src/otsp_pkg.sv @@
// ----------------------------------------------------------------------------
// otsp_pkg
// Constants, codes and shared types of the one-shot timer slot pool.
// ----------------------------------------------------------------------------
package otsp_pkg;

	localparam int NUM_SLOTS   = 8;
	localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W       = $clog2(NUM_SLOTS + 1);
	localparam int MAX_RESULTS = 8;
	localparam int NUM_W       = $clog2(MAX_RESULTS + 1);
	localparam int DL_W        = 32;
	localparam int SECS_W      = 23;

	// x * 1000 = (x << 10) - (x << 4) - (x << 3)
	localparam int MS_SH_HI  = 10;
	localparam int MS_SH_MID = 4;
	localparam int MS_SH_LO  = 3;

	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_SET    = 2'd1,
		CMD_CANCEL = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		EVT_SET    = 2'd0,
		EVT_CANCEL = 2'd1,
		EVT_EXPIRE = 2'd2
	} evt_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_A,
		ST_MUL_B,
		ST_ADD,
		ST_SCAN
	} state_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		alu_op_t         op;
		logic [DL_W-1:0] a;
		logic [DL_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [DL_W-1:0] res;
		logic            ge;
	} alu_rsp_t;

	// Low three bits of a slot number, zero-extended for narrow pools
	function automatic logic [2:0] slot_code(input logic [SLOT_W-1:0] s);
		logic [SLOT_W+2:0] t;
		t = (SLOT_W + 3)'(s);
		return t[2:0];
	endfunction

endpackage

@@ src/one_shot_timer_slot_pool_core.sv @@
// ----------------------------------------------------------------------------
// one_shot_timer_slot_pool_core
// Pool of one-shot timer slots: set, cancel and tick-driven expiry.
// ----------------------------------------------------------------------------
// A command transfers on a rising edge with start high and busy low; busy
// stays high until the command is finished. Each result shows on the result
// ports for exactly one cycle with strobe high, and the receiver cannot hold
// it off. Cancel answers in the cycle after the transfer, and a set that
// finds no idle slot does too; a successful set steps through MUL_A, MUL_B
// and ADD, busy in each, as the shared adder builds now + seconds * 1000 by
// shift-and-subtract and the result is written to the deadline RAM. A tick
// reads one deadline per cycle through the single RAM read port and compares
// it in the same adder; expiry events come out in slot order, at most one
// per cycle, all but the final one during the scan, the final one flagged by last.
// ----------------------------------------------------------------------------
module one_shot_timer_slot_pool_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        command,
	input  logic [31:0]       now_ms,
	input  logic [22:0]       duration_seconds,
	input  logic signed [7:0] timer_id,
	output logic              strobe,
	output logic [1:0]        event_kind,
	output logic [2:0]        slot,
	output logic              ok,
	output logic              last
);
	import otsp_pkg::*;

	alu_req_t          alu_req;
	alu_rsp_t          alu_rsp;
	logic              ram_we;
	logic [SLOT_W-1:0] ram_waddr;
	logic [DL_W-1:0]   ram_wdata;
	logic [SLOT_W-1:0] ram_raddr;
	logic [DL_W-1:0]   ram_rdata;

	otsp_seq u_seq (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.command          (command),
		.now_ms           (now_ms),
		.duration_seconds (duration_seconds),
		.timer_id         (timer_id),
		.strobe           (strobe),
		.event_kind       (event_kind),
		.slot             (slot),
		.ok               (ok),
		.last             (last),
		.alu_req          (alu_req),
		.alu_rsp          (alu_rsp),
		.ram_we           (ram_we),
		.ram_waddr        (ram_waddr),
		.ram_wdata        (ram_wdata),
		.ram_raddr        (ram_raddr),
		.ram_rdata        (ram_rdata)
	);

	otsp_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	otsp_ram #(
		.WIDTH  (DL_W),
		.DEPTH  (NUM_SLOTS),
		.ADDR_W (SLOT_W)
	) u_deadline_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

@@ src/otsp_ram.sv @@
// ----------------------------------------------------------------------------
// otsp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module otsp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ src/otsp_alu.sv @@
// ----------------------------------------------------------------------------
// otsp_alu
// Shared 32-bit add/subtract unit; the carry out of a subtract gives a >= b.
// ----------------------------------------------------------------------------
module otsp_alu (
	input  otsp_pkg::alu_req_t req,
	output otsp_pkg::alu_rsp_t rsp
);
	import otsp_pkg::*;

	logic            sub;
	logic [DL_W-1:0] b_op;
	logic [DL_W:0]   sum;

	always_comb begin
		sub  = (req.op == ALU_SUB);
		b_op = sub ? ~req.b : req.b;
		sum  = {1'b0, req.a} + {1'b0, b_op} + (DL_W + 1)'(sub);
		rsp.res = sum[DL_W-1:0];
		rsp.ge  = sub & sum[DL_W];
	end

endmodule

@@ src/otsp_seq.sv @@
// ----------------------------------------------------------------------------
// otsp_seq
// Command sequencer: slot allocation, cancel check, deadline build and the
// expiry scan, all driving the shared ALU and the deadline RAM.
// ----------------------------------------------------------------------------
module otsp_seq (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [1:0]                           command,
	input  logic [31:0]                          now_ms,
	input  logic [22:0]                          duration_seconds,
	input  logic signed [7:0]                    timer_id,
	output logic                                 strobe,
	output logic [1:0]                           event_kind,
	output logic [2:0]                           slot,
	output logic                                 ok,
	output logic                                 last,
	output otsp_pkg::alu_req_t                   alu_req,
	input  otsp_pkg::alu_rsp_t                   alu_rsp,
	output logic                                 ram_we,
	output logic [otsp_pkg::SLOT_W-1:0]          ram_waddr,
	output logic [otsp_pkg::DL_W-1:0]            ram_wdata,
	output logic [otsp_pkg::SLOT_W-1:0]          ram_raddr,
	input  logic [otsp_pkg::DL_W-1:0]            ram_rdata
);
	import otsp_pkg::*;

	state_t              state_q, state_d;
	logic [NUM_SLOTS-1:0] active_q;
	logic [DL_W-1:0]     now_q;
	logic [SECS_W-1:0]   secs_q;
	logic [DL_W-1:0]     acc_q;
	logic [SLOT_W-1:0]   set_slot_q;
	logic [CNT_W-1:0]    idx_q;
	logic                cmp_valid_s1;
	logic [SLOT_W-1:0]   cmp_idx_s1;
	logic                pend_valid_q;
	logic [SLOT_W-1:0]   pend_slot_q;
	logic [NUM_W-1:0]    n_q;

	logic                strobe_q, ok_q, last_q;
	logic [1:0]          kind_q;
	logic [2:0]          slot_q;

	logic                accept;
	logic                free_found;
	logic [SLOT_W-1:0]   free_idx;
	logic [7:0]          id_u;
	logic [SLOT_W-1:0]   cancel_idx;
	logic                cancel_ok;
	logic                scan_issue, scan_due, scan_end;
	logic [DL_W-1:0]     secs_ext;

	assign accept = start && !busy;

	// Lowest idle slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_found = 1'b1;
				free_idx   = SLOT_W'(i);
			end
		end
	end

	// A negative id reads as 128 or more and fails the range check
	always_comb begin
		id_u       = unsigned'(timer_id);
		cancel_idx = id_u[SLOT_W-1:0];
		cancel_ok  = (id_u < 8'(NUM_SLOTS)) && active_q[cancel_idx];
	end

	always_comb begin
		scan_issue = (idx_q < CNT_W'(NUM_SLOTS));
		scan_due   = (state_q == ST_SCAN) && cmp_valid_s1 && active_q[cmp_idx_s1]
			&& alu_rsp.ge && (n_q < NUM_W'(MAX_RESULTS));
		scan_end   = (state_q == ST_SCAN) && !cmp_valid_s1 && !scan_issue;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (command)
						CMD_SET: begin
							if (free_found) begin
								state_d = ST_MUL_A;
							end
						end
						CMD_TICK: state_d = ST_SCAN;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_MUL_A: state_d = ST_MUL_B;
			ST_MUL_B: state_d = ST_ADD;
			ST_ADD:   state_d = ST_IDLE;
			ST_SCAN: begin
				if (scan_end) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Datapath control
	always_comb begin
		secs_ext    = DL_W'(secs_q);
		busy        = (state_q != ST_IDLE);
		alu_req.op  = ALU_ADD;
		alu_req.a   = now_q;
		alu_req.b   = acc_q;
		ram_we      = 1'b0;
		case (state_q)
			ST_MUL_A: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = secs_ext << MS_SH_HI;
				alu_req.b  = secs_ext << MS_SH_MID;
			end
			ST_MUL_B: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = acc_q;
				alu_req.b  = secs_ext << MS_SH_LO;
			end
			ST_ADD: begin
				ram_we = 1'b1;
			end
			ST_SCAN: begin
				alu_req.op = ALU_SUB;
				alu_req.b  = ram_rdata;
			end
			default: begin
				alu_req.op = ALU_ADD;
			end
		endcase
		ram_waddr = set_slot_q;
		ram_wdata = alu_rsp.res;
		ram_raddr = idx_q[SLOT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			active_q     <= '0;
			strobe_q     <= 1'b0;
			cmp_valid_s1 <= 1'b0;
			pend_valid_q <= 1'b0;
			n_q          <= '0;
			idx_q        <= '0;
		end else begin
			state_q  <= state_d;
			strobe_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						now_q  <= now_ms;
						secs_q <= duration_seconds;
						case (command)
							CMD_SET: begin
								set_slot_q <= free_idx;
								if (!free_found) begin
									strobe_q <= 1'b1;
									kind_q   <= EVT_SET;
									slot_q   <= 3'd0;
									ok_q     <= 1'b0;
									last_q   <= 1'b1;
								end
							end
							CMD_CANCEL: begin
								if (cancel_ok) begin
									active_q[cancel_idx] <= 1'b0;
								end
								strobe_q <= 1'b1;
								kind_q   <= EVT_CANCEL;
								slot_q   <= 3'd0;
								ok_q     <= cancel_ok;
								last_q   <= 1'b1;
							end
							CMD_TICK: begin
								idx_q        <= '0;
								cmp_valid_s1 <= 1'b0;
								pend_valid_q <= 1'b0;
								n_q          <= '0;
							end
							default: begin
								strobe_q <= 1'b0;
							end
						endcase
					end
				end
				ST_MUL_A, ST_MUL_B: begin
					acc_q <= alu_rsp.res;
				end
				ST_ADD: begin
					active_q[set_slot_q] <= 1'b1;
					strobe_q <= 1'b1;
					kind_q   <= EVT_SET;
					slot_q   <= slot_code(set_slot_q);
					ok_q     <= 1'b1;
					last_q   <= 1'b1;
				end
				ST_SCAN: begin
					// Issue the next read; compare the previous one
					if (scan_issue) begin
						cmp_valid_s1 <= 1'b1;
						cmp_idx_s1   <= idx_q[SLOT_W-1:0];
						idx_q        <= idx_q + CNT_W'(1);
					end else begin
						cmp_valid_s1 <= 1'b0;
					end
					// Hold each hit until the next one shows it is not the final one
					if (scan_due) begin
						active_q[cmp_idx_s1] <= 1'b0;
						pend_slot_q  <= cmp_idx_s1;
						pend_valid_q <= 1'b1;
						n_q          <= n_q + NUM_W'(1);
						if (pend_valid_q) begin
							strobe_q <= 1'b1;
							kind_q   <= EVT_EXPIRE;
							slot_q   <= slot_code(pend_slot_q);
							ok_q     <= 1'b1;
							last_q   <= 1'b0;
						end
					end
					if (scan_end && pend_valid_q) begin
						strobe_q <= 1'b1;
						kind_q   <= EVT_EXPIRE;
						slot_q   <= slot_code(pend_slot_q);
						ok_q     <= 1'b1;
						last_q   <= 1'b1;
					end
				end
				default: begin
					strobe_q <= 1'b0;
				end
			endcase
		end
	end

	assign strobe     = strobe_q;
	assign event_kind = kind_q;
	assign slot       = slot_q;
	assign ok         = ok_q;
	assign last       = last_q;

endmodule

@@ src/otsp_checker.sv @@
// ----------------------------------------------------------------------------
// otsp_checker
// Port-level checks of the timer slot pool, bound to the top level.
// ----------------------------------------------------------------------------
`include "one_shot_timer_slot_pool_core_macros.svh"

module otsp_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic [1:0]        command,
	input logic              strobe,
	input logic [1:0]        event_kind,
	input logic [2:0]        slot,
	input logic              ok,
	input logic              last
);
	import otsp_pkg::*;

	// Set and cancel answers stand alone
	`OTSP_ASSERT_IMPL(a_answer_is_last, strobe && (event_kind != EVT_EXPIRE), last)
	// A cancel transfer is answered on the next cycle
	`OTSP_ASSERT_NEXT(a_cancel_answer, start && !busy && (command == CMD_CANCEL), strobe && (event_kind == EVT_CANCEL) && last && (slot == 3'd0))
	// Expiry events other than the final one come while the scan runs
	`OTSP_ASSERT_IMPL(a_expire_mid_busy, strobe && (event_kind == EVT_EXPIRE) && !last, busy)
	// The final expiry event ends the tick
	`OTSP_ASSERT_IMPL(a_expire_last_idle, strobe && (event_kind == EVT_EXPIRE) && last, !busy && ok)

endmodule

bind one_shot_timer_slot_pool_core otsp_checker u_otsp_checker (.*);

@@ bench/one_shot_timer_slot_pool_core_chk.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// one_shot_timer_slot_pool_core_chk
// Watches the command and result channels of the timer slot pool, keeps its
// own copy of the slot table, predicts every result and compares in order.
// ----------------------------------------------------------------------------
module one_shot_timer_slot_pool_core_chk (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic [1:0]        command,
	input  logic [31:0]       now_ms,
	input  logic [22:0]       duration_seconds,
	input  logic signed [7:0] timer_id,
	input  logic              strobe,
	input  logic [1:0]        event_kind,
	input  logic [2:0]        slot,
	input  logic              ok,
	input  logic              last,
	output int                fail_count,
	output int                pending,
	output int                checked
);
	import otsp_pkg::*;

	typedef struct {
		evt_t       kind;
		logic [2:0] slot;
		logic       ok;
		logic       last;
	} pool_event_t;

	pool_event_t due_events[$];
	logic        slot_live [NUM_SLOTS];
	logic [31:0] slot_expiry_ms [NUM_SLOTS];
	int          expired_slots[$];
	int          mismatches;
	int          results;

	always @(posedge clk or negedge arst_n) begin
		pool_event_t want;
		logic [31:0] span_ms;
		int          id;
		bit          hit;
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				slot_live[i]      = 1'b0;
				slot_expiry_ms[i] = '0;
			end
			due_events.delete();
			mismatches = 0;
			results    = 0;
		end else begin
			// check the result transfer first: a command's results never share its edge
			if (strobe) begin
				results++;
				if (due_events.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result kind %0d slot %0d ok %b last %b",
							$time, event_kind, slot, ok, last);
				end else begin
					want = due_events.pop_front();
					if (event_kind !== want.kind || slot !== want.slot ||
					    ok !== want.ok || last !== want.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"%0t: mismatch, expected kind %0d slot %0d ok %b last %b,",
								" got kind %0d slot %0d ok %b last %b"}, $time,
								want.kind, want.slot, want.ok, want.last,
								event_kind, slot, ok, last);
					end
				end
			end

			if (start && !busy) begin
				case (command)
				CMD_SET: begin
					hit = 1'b0;
					for (int i = 0; i < NUM_SLOTS; i++) begin
						if (!hit && !slot_live[i]) begin
							hit = 1'b1;
							// product wraps at 32 bits, as does the sum
							span_ms = 32'(duration_seconds) * 32'd1000;
							slot_expiry_ms[i] = now_ms + span_ms;
							slot_live[i] = 1'b1;
							due_events.push_back('{EVT_SET, 3'(i), 1'b1, 1'b1});
						end
					end
					if (!hit)
						due_events.push_back('{EVT_SET, 3'd0, 1'b0, 1'b1});
				end
				CMD_CANCEL: begin
					id  = timer_id;
					hit = 1'b0;
					if (id >= 0 && id < NUM_SLOTS) begin
						if (slot_live[id]) begin
							slot_live[id] = 1'b0;
							hit = 1'b1;
						end
					end
					due_events.push_back('{EVT_CANCEL, 3'd0, hit, 1'b1});
				end
				CMD_TICK: begin
					expired_slots.delete();
					for (int i = 0; i < NUM_SLOTS; i++)
						if (slot_live[i] && now_ms >= slot_expiry_ms[i] &&
						    expired_slots.size() < MAX_RESULTS)
							expired_slots.push_back(i);
					foreach (expired_slots[k]) begin
						slot_live[expired_slots[k]] = 1'b0;
						due_events.push_back('{EVT_EXPIRE, 3'(expired_slots[k]), 1'b1,
							k == expired_slots.size() - 1});
					end
				end
				default: ; // drop the unused code
				endcase
			end
		end
		fail_count <= mismatches;
		pending    <= due_events.size();
		checked    <= results;
	end

endmodule

@@ bench/one_shot_timer_slot_pool_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// one_shot_timer_slot_pool_core_tb
// Drives set, cancel and tick commands into the timer slot pool: a directed
// opening over full pools, refused cancels and wrapping deadlines, then random
// traffic around a moving millisecond clock; the checker judges every result.
// ----------------------------------------------------------------------------
module one_shot_timer_slot_pool_core_tb;
	import otsp_pkg::*;

	localparam logic [1:0] CMD_UNUSED   = 2'd3;
	localparam int RANDOM_ITEMS  = 208;
	localparam int QUIET_ITEMS   = 30;
	localparam int SETTLE_CYCLES = 4 * NUM_SLOTS;
	localparam int CYCLE_LIMIT   = 200000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic [1:0]        command = '0;
	logic [31:0]       now_ms = '0;
	logic [22:0]       duration_seconds = '0;
	logic signed [7:0] timer_id = '0;
	logic              busy;
	logic              strobe;
	logic [1:0]        event_kind;
	logic [2:0]        slot;
	logic              ok;
	logic              last;

	int fail_count;
	int pending;
	int checked;
	int cycle_count = 0;
	int n_set = 0;
	int n_cancel = 0;
	int n_tick = 0;
	int n_unused = 0;
	logic [31:0] wall_ms;

	always #4 clk = ~clk;

	one_shot_timer_slot_pool_core u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.command          (command),
		.now_ms           (now_ms),
		.duration_seconds (duration_seconds),
		.timer_id         (timer_id),
		.strobe           (strobe),
		.event_kind       (event_kind),
		.slot             (slot),
		.ok               (ok),
		.last             (last)
	);

	one_shot_timer_slot_pool_core_chk u_chk (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.command          (command),
		.now_ms           (now_ms),
		.duration_seconds (duration_seconds),
		.timer_id         (timer_id),
		.strobe           (strobe),
		.event_kind       (event_kind),
		.slot             (slot),
		.ok               (ok),
		.last             (last),
		.fail_count       (fail_count),
		.pending          (pending),
		.checked          (checked)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Hold start high until the command transfers; start stays high on return
	task automatic issue(input logic [1:0] cmd, input logic [31:0] now,
	                     input logic [22:0] secs, input logic [7:0] id);
		start            <= 1'b1;
		command          <= cmd;
		now_ms           <= now;
		duration_seconds <= secs;
		timer_id         <= id;
		do @(posedge clk); while (busy);
		case (cmd)
		CMD_SET:    n_set++;
		CMD_CANCEL: n_cancel++;
		CMD_TICK:   n_tick++;
		default:    n_unused++;
		endcase
	endtask

	task automatic pause(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Hold off until the pool is idle and every predicted result has come
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
	endtask

	initial begin
		int          pick;
		logic [22:0] secs;
		logic [7:0]  id;
		logic [31:0] now;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty pool: tick gives nothing, every cancel is refused
		issue(CMD_TICK, 32'd0, 23'd0, 8'd0);
		issue(CMD_CANCEL, 32'd0, 23'd0, 8'd0);
		issue(CMD_CANCEL, 32'd0, 23'd0, 8'hFF);
		issue(CMD_CANCEL, 32'd0, 23'd0, 8'h80);
		issue(CMD_CANCEL, 32'd0, 23'd0, 8'd8);
		issue(CMD_CANCEL, 32'd0, 23'd0, 8'h7F);
		// fill every slot, two of them with wrapping deadlines
		issue(CMD_SET, 32'd1000, 23'd0, 8'd0);
		issue(CMD_SET, 32'hFFFF_FFFF, 23'd1, 8'd0);
		issue(CMD_SET, 32'd0, 23'h7F_FFFF, 8'd0);
		for (int i = 3; i < NUM_SLOTS; i++)
			issue(CMD_SET, 32'd500, 23'd2, 8'd0);
		issue(CMD_SET, 32'd0, 23'd1, 8'd0);
		issue(CMD_CANCEL, 32'd0, 23'd0, 8'd3);
		issue(CMD_CANCEL, 32'd0, 23'd0, 8'd3);
		issue(CMD_SET, 32'd100, 23'd5, 8'd0);
		// deadline exactly equal to now expires, one millisecond short does not
		issue(CMD_TICK, 32'd999, 23'd0, 8'd0);
		issue(CMD_SET, 32'd0, 23'd0, 8'd0);
		issue(CMD_UNUSED, 32'hFFFF_FFFF, 23'h7F_FFFF, 8'hFF);
		issue(CMD_TICK, 32'hFFFF_FFFF, 23'd0, 8'd0);
		drain();

		// start near the top half the time so deadlines wrap during the run
		wall_ms = $urandom_range(0, 1) ? 32'hFFFF_0000 : 32'd0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 99);
			secs = 23'($urandom());
			id   = 8'($urandom());
			now  = $urandom();
			if (pick < 40) begin
				if ($urandom_range(0, 9) != 0)
					secs = 23'($urandom_range(0, 4));
				if ($urandom_range(0, 9) != 0)
					now = wall_ms;
				issue(CMD_SET, now, secs, id);
			end else if (pick < 58) begin
				if ($urandom_range(0, 3) != 0)
					id = 8'($urandom_range(0, NUM_SLOTS - 1));
				issue(CMD_CANCEL, now, secs, id);
			end else if (pick < 95) begin
				if ($urandom_range(0, 11) == 0)
					wall_ms = $urandom();
				else
					wall_ms = wall_ms + $urandom_range(0, 2500);
				issue(CMD_TICK, wall_ms, secs, id);
			end else begin
				issue(CMD_UNUSED, now, secs, id);
			end

			if (n == 100 || n == 170)
				drain();
			else if (n < RANDOM_ITEMS - QUIET_ITEMS && $urandom_range(0, 3) == 0)
				pause($urandom_range(1, 4));
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Run covered %0d sets, %0d cancels, %0d ticks and %0d unused commands,",
			n_set, n_cancel, n_tick, n_unused);
		$display("with %0d results compared against the predicted slot table.", checked);
		if (fail_count == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
